// ----- hdl/long_fir_convolver_macros.svh -----
// Assertion macros for the long FIR convolver.
// Used by the top level; expects clk and arst_n in scope.
`ifndef LONG_FIR_CONVOLVER_MACROS_SVH
`define LONG_FIR_CONVOLVER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define LFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/lfc_pkg.sv -----
// Shared types and constants for the long FIR convolver.
// No dependencies; imported by the interface users, the MAC and the top level.
package lfc_pkg;

	localparam int SAMPLE_W = 24;
	localparam int COEFF_W  = 24;
	localparam int INDEX_W  = 10;
	localparam int TAPREG_W = 11;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// Command codes
	localparam logic [1:0] CMD_FILTER = 2'd0;
	localparam logic [1:0] CMD_COEFF  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Register index (paddr[2])
	localparam logic REG_TAP_COUNT = 1'b0;

	// 1.0 in Q2.22
	localparam logic [COEFF_W-1:0] UNIT_COEFF = 24'h400000;

	// Output range and rounding
	localparam int OUT_MAX    = 8388607;
	localparam int OUT_MIN    = -8388608;
	localparam int ROUND_BIAS = 2097152;
	localparam int FRAC_SHIFT = 22;

	typedef struct packed {
		logic [1:0]                 command;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [INDEX_W-1:0]         coeff_index;
		logic signed [COEFF_W-1:0]  coeff_value;
	} lfc_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       saturated;
	} lfc_out_t;

	// Control from the sequencer to the MAC
	typedef struct packed {
		logic clear;     // zero the accumulator
		logic rd_valid;  // RAM read data valid this cycle
		logic hist_ok;   // history word holds a real sample
	} lfc_mac_ctl_t;

endpackage

// ----- hdl/lfc_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct.
// Payload type supplied by the instantiating level (see lfc_pkg).
interface lfc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/lfc_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module lfc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

// ----- hdl/lfc_apb.sv -----
// APB configuration register file: holds tap_count.
// Depends on lfc_pkg.
module lfc_apb (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lfc_pkg::PADDR_W-1:0]  paddr,
	input  logic [lfc_pkg::PDATA_W-1:0]  pwdata,
	output logic [lfc_pkg::PDATA_W-1:0]  prdata,
	output logic [lfc_pkg::TAPREG_W-1:0] tap_count
);
	import lfc_pkg::*;

	logic [TAPREG_W-1:0] tap_count_q;
	logic                sel_tap;

	assign sel_tap = (paddr[2] == REG_TAP_COUNT);

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAPREG_W'(1);
		end else if (psel && penable && pwrite && sel_tap) begin
			tap_count_q <= pwdata[TAPREG_W-1:0];
		end
	end

	// Read mux
	assign prdata    = sel_tap ? PDATA_W'(tap_count_q) : '0;
	assign tap_count = tap_count_q;
endmodule

// ----- hdl/lfc_mac.sv -----
// Multiply-accumulate datapath with rounding and saturation.
// Depends on lfc_pkg; fed by the coefficient and history RAMs.
module lfc_mac #(
	parameter int MAX_TAPS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lfc_pkg::lfc_mac_ctl_t               ctl,
	input  logic [lfc_pkg::COEFF_W-1:0]         coeff,
	input  logic [lfc_pkg::SAMPLE_W-1:0]        hist,
	output logic                                busy,
	output logic signed [lfc_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                saturated
);
	import lfc_pkg::*;

	localparam int PROD_W = SAMPLE_W + COEFF_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
	localparam int RND_W  = ACC_W - FRAC_SHIFT;
	localparam logic signed [RND_W-1:0] HI = RND_W'(OUT_MAX);
	localparam logic signed [RND_W-1:0] LO = RND_W'(OUT_MIN);
	localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(ROUND_BIAS);

	logic                       mul_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] hist_m;
	logic signed [ACC_W-1:0]    biased;
	logic signed [RND_W-1:0]    rounded;

	// Masked history: slots not written since the last clear read as zero
	assign hist_m = ctl.hist_ok ? $signed(hist) : '0;

	// Product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s2 <= 1'b0;
		end else begin
			mul_s2 <= ctl.rd_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(coeff) * hist_m;
	end

	// Accumulator
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (mul_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up, then clamp
	assign biased  = acc_q + BIAS;
	assign rounded = RND_W'(biased >>> FRAC_SHIFT);

	always_comb begin
		if (rounded > HI) begin
			sample_out = SAMPLE_W'(HI);
			saturated  = 1'b1;
		end else if (rounded < LO) begin
			sample_out = SAMPLE_W'(LO);
			saturated  = 1'b1;
		end else begin
			sample_out = rounded[SAMPLE_W-1:0];
			saturated  = 1'b0;
		end
	end

	assign busy = mul_s2;
endmodule

// ----- hdl/long_fir_convolver.sv -----
// Long FIR convolver top level: sequencer, coefficient and history RAMs.
// Depends on lfc_pkg, lfc_stream_if, lfc_ram, lfc_apb, lfc_mac and the macro header.
//
//  channel   dir  handshake        payload
//  ingress   in   valid/ready      command, sample_in, coeff_index, coeff_value
//  egress    out  valid/ready      sample_out, saturated
//  apb       in   psel/penable     tap_count at paddr 0 (pready tied high)
//
// A filter transaction stores the sample, then runs one multiply-accumulate per tap of
// min(tap_count, MAX_TAPS), bounded by the single read port of each RAM, then drains.
// Coefficient writes and history clears are done as they are accepted.
// After reset a pass over all MAX_TAPS entries loads the coefficient RAM with the unit
// impulse; ingress.ready stays low meanwhile.
// A new transaction is accepted while a result waits in the egress register;
// a finished sum waits until that register is free.
`include "long_fir_convolver_macros.svh"

module long_fir_convolver #(
	parameter int MAX_TAPS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lfc_pkg::PADDR_W-1:0]  paddr,
	input  logic [lfc_pkg::PDATA_W-1:0]  pwdata,
	output logic [lfc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	lfc_stream_if.sink                   ingress,
	lfc_stream_if.source                 egress
);
	import lfc_pkg::*;

	localparam int AW = $clog2(MAX_TAPS);
	localparam int TW = $clog2(MAX_TAPS + 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_STORE,
		S_RUN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         h_q;
	logic [TW-1:0]         k_q;
	logic [TW-1:0]         fill_q;
	logic [SAMPLE_W-1:0]   sample_q;
	logic                  rd_s1;
	logic                  hist_ok_s1;
	logic                  out_valid_q;
	lfc_out_t              out_pl_q;

	logic [TAPREG_W-1:0]   tap_count;
	logic [TW-1:0]         taps;
	logic                  accept;
	logic                  coeff_we;
	logic [AW-1:0]         coeff_addr;
	logic [COEFF_W-1:0]    coeff_wdata;
	logic [COEFF_W-1:0]    coeff_rdata;
	logic                  hist_we;
	logic [AW-1:0]         hist_addr;
	logic [SAMPLE_W-1:0]   hist_rdata;
	lfc_mac_ctl_t          mac_ctl;
	logic                  mac_busy;
	logic signed [SAMPLE_W-1:0] mac_out;
	logic                  mac_sat;

	// Configuration
	lfc_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.tap_count (tap_count)
	);
	assign pready = 1'b1;

	// Taps in use, limited to the table depth
	assign taps = (32'(tap_count) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(tap_count);

	assign ingress.ready = (state_q == S_IDLE);
	assign accept        = ingress.valid && ingress.ready;

	// Coefficient RAM port
	always_comb begin
		coeff_we    = 1'b0;
		coeff_addr  = k_q[AW-1:0];
		coeff_wdata = ingress.payload.coeff_value;
		if (state_q == S_CLEAR) begin
			coeff_we    = 1'b1;
			coeff_addr  = clr_q;
			coeff_wdata = (clr_q == '0) ? UNIT_COEFF : '0;
		end else if (accept && ingress.payload.command == CMD_COEFF) begin
			coeff_addr = AW'(ingress.payload.coeff_index);
			coeff_we   = (32'(ingress.payload.coeff_index) < MAX_TAPS);
		end
	end

	// History RAM port
	assign hist_we   = (state_q == S_STORE);
	assign hist_addr = hist_we ? ptr_q : h_q;

	lfc_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_TAPS)) u_coeff_ram (
		.clk   (clk),
		.addr  (coeff_addr),
		.we    (coeff_we),
		.wdata (coeff_wdata),
		.rdata (coeff_rdata)
	);

	lfc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist_ram (
		.clk   (clk),
		.addr  (hist_addr),
		.we    (hist_we),
		.wdata (sample_q),
		.rdata (hist_rdata)
	);

	// MAC
	assign mac_ctl.clear    = (state_q == S_STORE);
	assign mac_ctl.rd_valid = rd_s1;
	assign mac_ctl.hist_ok  = hist_ok_s1;

	lfc_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mac_ctl),
		.coeff      (coeff_rdata),
		.hist       (hist_rdata),
		.busy       (mac_busy),
		.sample_out (mac_out),
		.saturated  (mac_sat)
	);

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			ptr_q       <= '0;
			h_q         <= '0;
			k_q         <= '0;
			fill_q      <= '0;
			rd_s1       <= 1'b0;
			hist_ok_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1      <= (state_q == S_RUN);
			hist_ok_s1 <= (k_q < fill_q);
			// Output valid: load a finished sum, else drop on acceptance
			if (state_q == S_DONE && (!out_valid_q || egress.ready)) begin
				out_valid_q <= 1'b1;
			end else if (egress.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_TAPS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (ingress.payload.command)
							CMD_FILTER: begin
								state_q <= S_STORE;
							end
							CMD_CLEAR: begin
								ptr_q  <= '0;
								fill_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_STORE: begin
					h_q   <= ptr_q;
					k_q   <= '0;
					ptr_q <= (ptr_q == AW'(MAX_TAPS - 1)) ? '0 : ptr_q + AW'(1);
					if (fill_q != TW'(MAX_TAPS)) begin
						fill_q <= fill_q + TW'(1);
					end
					state_q <= (taps == '0) ? S_DRAIN : S_RUN;
				end
				S_RUN: begin
					k_q <= k_q + TW'(1);
					h_q <= (h_q == '0) ? AW'(MAX_TAPS - 1) : h_q - AW'(1);
					if (k_q == taps - TW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_s1 && !mac_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || egress.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= ingress.payload.sample_in;
		end
		if (state_q == S_DONE && (!out_valid_q || egress.ready)) begin
			out_pl_q.sample_out <= mac_out;
			out_pl_q.saturated  <= mac_sat;
		end
	end

	assign egress.valid   = out_valid_q;
	assign egress.payload = out_pl_q;

	// Checks
	`LFC_ASSERT_NOW(a_ready_idle, ingress.ready, state_q == S_IDLE, "ready outside idle")
	`LFC_ASSERT_NEXT(a_filter_start, accept && ingress.payload.command == CMD_FILTER, state_q == S_STORE, "filter did not start")
	`LFC_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= TW'(MAX_TAPS), "history fill past depth")
	`LFC_ASSERT_NOW(a_done_drained, state_q == S_DONE, !rd_s1 && !mac_busy, "result taken before drain")

endmodule

// ----- sim/tb_top.sv -----
// Testbench for long_fir_convolver: a directed table, then random phases over tap counts.
// Depends on lfc_pkg, lfc_stream_if and the long_fir_convolver RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lfc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int DEPTH          = 1024;
	localparam int HOLD_CYCLES    = 3000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 1100;

	// Directed transaction with an optional hand-written result
	typedef struct {
		logic [1:0] cmd;
		int         smp;
		int         idx;
		int         coeff;
		bit         typed;
		int         want_out;
		bit         want_sat;
	} step_row_t;

	// Random phase: tap_count range, transaction count, gap-free flag, hold-off flag
	typedef struct {
		int unsigned taps_lo;
		int unsigned taps_hi;
		int unsigned count;
		bit          steady;
		bit          hold;
	} phase_t;

	localparam int N_ROWS   = 25;
	localparam int N_PHASES = 11;

	step_row_t step_rows [N_ROWS] = '{
		'{CMD_FILTER,        0,    0,        0, 1,        0, 0},
		'{CMD_FILTER,  8388607,    0,        0, 1,  8388607, 0},
		'{CMD_FILTER, -8388608,    0,        0, 1, -8388608, 0},
		'{CMD_FILTER,        1,    0,        0, 1,        1, 0},
		'{CMD_FILTER,       -1,    0,        0, 1,       -1, 0},
		'{CMD_UNUSED,       -1, 1023,       -1, 0,        0, 0},
		'{CMD_COEFF,         0,    0,  2097152, 0,        0, 0},
		'{CMD_FILTER,        1,    0,        0, 1,        1, 0},
		'{CMD_FILTER,       -1,    0,        0, 1,        0, 0},
		'{CMD_FILTER,        3,    0,        0, 1,        2, 0},
		'{CMD_FILTER,       -3,    0,        0, 1,       -1, 0},
		'{CMD_COEFF,         0,    0,  8388607, 0,        0, 0},
		'{CMD_FILTER,  8388607,    0,        0, 1,  8388607, 1},
		'{CMD_FILTER, -8388608,    0,        0, 1, -8388608, 1},
		'{CMD_COEFF,         0,    0, -8388608, 0,        0, 0},
		'{CMD_FILTER, -8388608,    0,        0, 1,  8388607, 1},
		'{CMD_FILTER,  8388607,    0,        0, 1, -8388608, 1},
		'{CMD_FILTER,        0,    0,        0, 1,        0, 0},
		'{CMD_COEFF,         0, 1023,  8388607, 0,        0, 0},
		'{CMD_COEFF,         0,    1,  4194304, 0,        0, 0},
		'{CMD_CLEAR,         0,    0,        0, 0,        0, 0},
		'{CMD_COEFF,         0,    0,  4194304, 0,        0, 0},
		'{CMD_FILTER,        5,    0,        0, 1,        5, 0},
		'{CMD_UNUSED,        0,    0,        0, 0,        0, 0},
		'{CMD_FILTER, -8388608,    0,        0, 1, -8388608, 0}
	};

	phase_t phases [N_PHASES] = '{
		'{0,    0,    30,  0, 0},
		'{1,    1,    30,  0, 0},
		'{2047, 2047, 16,  0, 0},
		'{2,    6,    60,  0, 0},
		'{1024, 1024, 16,  0, 0},
		'{2,    16,   80,  1, 0},
		'{4,    32,   80,  0, 1},
		'{1025, 1025, 8,   0, 0},
		'{2,    8,    100, 0, 0},
		'{17,   64,   80,  0, 0},
		'{2,    2,    80,  0, 0}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	lfc_stream_if #(.payload_t(lfc_in_t))  in_ch ();
	lfc_stream_if #(.payload_t(lfc_out_t)) out_ch ();

	long_fir_convolver #(
		.MAX_TAPS(DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ingress (in_ch),
		.egress  (out_ch)
	);

	// Predictor state: coefficients, sample ring, write slot, tap_count
	logic signed [COEFF_W-1:0]  coef_mem [DEPTH];
	logic signed [SAMPLE_W-1:0] hist_mem [DEPTH];
	logic [INDEX_W-1:0]         hist_ptr;
	logic [TAPREG_W-1:0]        tap_reg;

	lfc_out_t pending_results [$];

	int errors;
	int n_results;
	int n_saturated;
	int n_coeff;
	int n_clear;
	int n_settings;
	int stall_cycles;
	bit no_gaps;
	bit hold_armed;
	bit hold_done;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Direct-form FIR on the predictor state; returns 1 when a sample comes out
	function automatic bit fir_predict(input lfc_in_t item, output lfc_out_t res);
		int unsigned        taps;
		longint             acc;
		longint             rounded;
		logic [INDEX_W-1:0] slot;
		res = '0;
		case (item.command)
			CMD_COEFF: begin
				// 10-bit index never exceeds the table
				coef_mem[item.coeff_index] = item.coeff_value;
				return 1'b0;
			end
			CMD_CLEAR: begin
				foreach (hist_mem[i])
					hist_mem[i] = '0;
				hist_ptr = '0;
				return 1'b0;
			end
			CMD_FILTER: begin
				hist_mem[hist_ptr] = item.sample_in;
				taps = (tap_reg > DEPTH) ? DEPTH : tap_reg;
				acc = 0;
				for (int unsigned k = 0; k < taps; k++) begin
					slot = hist_ptr - INDEX_W'(k);
					acc += longint'(coef_mem[k]) * longint'(hist_mem[slot]);
				end
				// Q3.45 -> Q1.23, round half up, then clamp
				rounded = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
				if (rounded > OUT_MAX) begin
					rounded = OUT_MAX;
					res.saturated = 1'b1;
				end else if (rounded < OUT_MIN) begin
					rounded = OUT_MIN;
					res.saturated = 1'b1;
				end
				res.sample_out = rounded[SAMPLE_W-1:0];
				hist_ptr = hist_ptr + 1'b1;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Random transaction; span is the number of taps currently in use
	function automatic lfc_in_t random_item(input int unsigned span);
		lfc_in_t     it;
		int unsigned pick;
		it.command     = CMD_FILTER;
		it.sample_in   = SAMPLE_W'($urandom);
		it.coeff_index = INDEX_W'($urandom);
		it.coeff_value = COEFF_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 68) begin
			case ($urandom_range(5))
				0: it.sample_in = 24'h7FFFFF;
				1: it.sample_in = 24'h800000;
				2: it.sample_in = SAMPLE_W'(int'($urandom_range(511)) - 256);
				default: ;
			endcase
		end else if (pick < 92) begin
			it.command = CMD_COEFF;
			// mostly hit taps that are in use
			if ($urandom_range(3) != 0)
				it.coeff_index = INDEX_W'($urandom_range(span - 1));
			case ($urandom_range(5))
				0: it.coeff_value = UNIT_COEFF;
				1: it.coeff_value = 24'h7FFFFF;
				2: it.coeff_value = 24'h800000;
				3, 4: it.coeff_value = it.coeff_value >>> $urandom_range(12);
				default: ;
			endcase
		end else if (pick < 96) begin
			it.command = CMD_CLEAR;
		end else begin
			it.command = CMD_UNUSED;
		end
		return it;
	endfunction

	// One APB transfer to tap_count: setup, access until pready, then idle
	task automatic apb_access(input bit wr, input logic [TAPREG_W-1:0] value,
			output logic [PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_TAP_COUNT, 2'b00};
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_tap_count();
		logic [PDATA_W-1:0] rd;
		apb_access(1'b0, '0, rd);
		if (rd[TAPREG_W-1:0] !== tap_reg) begin
			$display("%0t ns: tap_count readback mismatch: expected %0d, actual %0d",
				$time, tap_reg, rd[TAPREG_W-1:0]);
			errors++;
		end
	endtask

	// Write tap_count once the block has drained
	task automatic set_tap_count(input logic [TAPREG_W-1:0] value);
		logic [PDATA_W-1:0] rd;
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, value, rd);
		tap_reg = value;
		n_settings++;
		read_tap_count();
	endtask

	// Offer one transaction, wait for acceptance, queue what it should produce
	task automatic send_item(input lfc_in_t item, input bit typed, input lfc_out_t typed_res);
		lfc_out_t res;
		bit       has_result;
		while (!no_gaps && $urandom_range(99) < 36) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= item;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		has_result = fir_predict(item, res);
		if (item.command == CMD_COEFF)
			n_coeff++;
		if (item.command == CMD_CLEAR)
			n_clear++;
		if (has_result)
			pending_results.push_back(typed ? typed_res : res);
	endtask

	// Main sequence
	initial begin : stimulus
		lfc_in_t     item;
		lfc_out_t    typed_res;
		int unsigned taps;
		int unsigned span;
		int unsigned sent;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		foreach (coef_mem[i]) begin
			coef_mem[i] = '0;
			hist_mem[i] = '0;
		end
		coef_mem[0] = UNIT_COEFF;
		hist_ptr    = '0;
		tap_reg     = TAPREG_W'(1);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_tap_count();

		// Directed table at the reset tap_count of one
		foreach (step_rows[r]) begin
			item.command         = step_rows[r].cmd;
			item.sample_in       = step_rows[r].smp[SAMPLE_W-1:0];
			item.coeff_index     = step_rows[r].idx[INDEX_W-1:0];
			item.coeff_value     = step_rows[r].coeff[COEFF_W-1:0];
			typed_res.sample_out = step_rows[r].want_out[SAMPLE_W-1:0];
			typed_res.saturated  = step_rows[r].want_sat;
			send_item(item, step_rows[r].typed, typed_res);
		end

		// Random phases, each at its own tap_count
		foreach (phases[p]) begin
			taps = $urandom_range(phases[p].taps_hi, phases[p].taps_lo);
			set_tap_count(TAPREG_W'(taps));
			no_gaps = phases[p].steady;
			span = (taps == 0) ? 1 : ((taps > DEPTH) ? DEPTH : taps);
			sent = 0;
			while (sent < phases[p].count) begin
				if (phases[p].hold && sent == 12 && !hold_done) begin
					hold_armed = 1'b1;
					hold_done  = 1'b1;
				end
				item = random_item(span);
				send_item(item, 1'b0, '0);
				if (item.command != CMD_UNUSED)
					sent++;
			end
			no_gaps = 1'b0;
		end

		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d filtered samples checked (%0d clamped), %0d coefficient writes, %0d clears",
			n_results, n_saturated, n_coeff, n_clear);
		$display("tb: %0d tap_count settings incl. 0, 1024 and 2047, one %0d-cycle output hold-off",
			n_settings, HOLD_CYCLES);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Output side: random stalls, gap-free in steady phases, one long hold-off
	initial begin : sink_side
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed) begin
				hold_armed = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ch.ready <= no_gaps || ($urandom_range(99) >= 36);
		end
	end

	// Compare each output transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		lfc_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected output: expected none, actual %0d sat %0b",
					$time, out_ch.payload.sample_out, out_ch.payload.saturated);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_results++;
				if (want.saturated)
					n_saturated++;
				if (out_ch.payload.sample_out !== want.sample_out) begin
					$display("%0t ns: sample_out mismatch: expected %0d, actual %0d",
						$time, want.sample_out, out_ch.payload.sample_out);
					errors++;
				end
				if (out_ch.payload.saturated !== want.saturated) begin
					$display("%0t ns: saturated mismatch: expected %0b, actual %0b",
						$time, want.saturated, out_ch.payload.saturated);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles", $time, stall_cycles);
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/lfc_pkg.sv
hdl/lfc_stream_if.sv
hdl/lfc_ram.sv
hdl/lfc_apb.sv
hdl/lfc_mac.sv
hdl/long_fir_convolver.sv
sim/tb_top.sv
